>>> sv/dro_pkg.sv
// Shared types and constants for the gauge readout core.
package dro_pkg;

    localparam int unsigned AXES    = 3;
    localparam int unsigned AXIS_W  = 2;
    localparam int unsigned MAG_W   = 20;
    localparam int unsigned VAL_W   = 21;
    localparam int unsigned DIFF_W  = 22;
    localparam int unsigned DISP_W  = 23;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SIGN_BIT = 4;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_ZERO  = 1'b1;

    localparam logic [1:0] CFG_FIRST_MODE  = 2'd0;
    localparam logic [1:0] CFG_SECOND_MODE = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

    localparam logic [1:0] FIRST_X  = 2'd0;
    localparam logic [1:0] FIRST_XY = 2'd1;
    localparam logic [1:0] FIRST_XZ = 2'd2;

    localparam logic SECOND_Y  = 1'b0;
    localparam logic SECOND_YZ = 1'b1;

    localparam logic [CNT_W-1:0] RETRY_RESET = 5'd30;
    localparam logic [CNT_W-1:0] CNT_MAX     = 5'd31;

    typedef struct packed {
        logic                    is_zero;
        logic                    ok;
        logic [AXIS_W-1:0]       axis;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       first_mode;
        logic             second_mode;
        logic [CNT_W-1:0] retry_limit;
    } t_cfg;

endpackage

>>> sv/dro_front.sv
// Input stage: takes items, checks the checksum and decodes the signed value.
module dro_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [dro_pkg::AXIS_W-1:0]    i_axis,
    input  logic [dro_pkg::BYTE_W-1:0]    i_low_byte,
    input  logic [dro_pkg::BYTE_W-1:0]    i_mid_byte,
    input  logic [dro_pkg::BYTE_W-1:0]    i_high_byte,
    input  logic [dro_pkg::BYTE_W-1:0]    i_check_byte,
    input  logic                          i_full,
    output logic                          o_push,
    output dro_pkg::t_cmd                 o_cmd
);

    logic                        r_valid;
    dro_pkg::t_cmd               r_cmd;
    dro_pkg::t_cmd               n_cmd;
    logic [dro_pkg::BYTE_W-1:0]  sum;
    logic [dro_pkg::VAL_W-1:0]   mag;

    always_comb begin
        sum = i_low_byte + i_mid_byte + i_high_byte;
        mag = {1'b0, i_high_byte[3:0], i_mid_byte, i_low_byte};
        n_cmd.is_zero = (i_action == dro_pkg::ACT_ZERO);
        n_cmd.ok      = (i_action == dro_pkg::ACT_FRAME) && (sum == i_check_byte);
        n_cmd.axis    = i_axis;
        n_cmd.value   = i_high_byte[dro_pkg::SIGN_BIT] ? -mag : mag;
    end

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

>>> sv/dro_fifo.sv
// Small register queue between the input and update stages.
module dro_fifo #(
    parameter int unsigned DEPTH = 2,
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/dro_back.sv
// Update stage: applies items to the axis state and registers the displays.
module dro_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dro_pkg::t_cmd                        i_cmd,
    input  logic                                 i_empty,
    output logic                                 o_pop,
    input  dro_pkg::t_cfg                        i_cfg,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_frame_ok,
    output logic signed [dro_pkg::DISP_W-1:0]    o_first_display,
    output logic signed [dro_pkg::DISP_W-1:0]    o_second_display,
    output logic signed [dro_pkg::DIFF_W-1:0]    o_third_display
);

    logic signed [dro_pkg::VAL_W-1:0]  r_val [dro_pkg::AXES];
    logic signed [dro_pkg::VAL_W-1:0]  r_off [dro_pkg::AXES];
    logic        [dro_pkg::CNT_W-1:0]  r_cnt [dro_pkg::AXES];
    logic signed [dro_pkg::VAL_W-1:0]  n_val [dro_pkg::AXES];
    logic signed [dro_pkg::VAL_W-1:0]  n_off [dro_pkg::AXES];
    logic        [dro_pkg::CNT_W-1:0]  n_cnt [dro_pkg::AXES];
    logic        [dro_pkg::CNT_W-1:0]  cnt_inc [dro_pkg::AXES];
    logic signed [dro_pkg::DIFF_W-1:0] diff [dro_pkg::AXES];
    logic signed [dro_pkg::DISP_W-1:0] first;
    logic signed [dro_pkg::DISP_W-1:0] second;
    logic                              r_valid;
    logic                              r_frame_ok;
    logic signed [dro_pkg::DISP_W-1:0] r_first;
    logic signed [dro_pkg::DISP_W-1:0] r_second;
    logic signed [dro_pkg::DIFF_W-1:0] r_third;

    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_comb begin
        for (int k = 0; k < dro_pkg::AXES; k++) begin
            n_val[k]   = r_val[k];
            n_off[k]   = r_off[k];
            n_cnt[k]   = r_cnt[k];
            cnt_inc[k] = (r_cnt[k] == dro_pkg::CNT_MAX) ? r_cnt[k] : r_cnt[k] + 1'b1;
            if (o_pop && (i_cmd.axis == dro_pkg::AXIS_W'(k))) begin
                if (i_cmd.is_zero) begin
                    n_off[k] = r_val[k];
                end else if (i_cmd.ok) begin
                    n_val[k] = i_cmd.value;
                    n_cnt[k] = '0;
                end else begin
                    n_cnt[k] = cnt_inc[k];
                    if (cnt_inc[k] >= i_cfg.retry_limit) begin
                        n_val[k] = '0;
                    end
                end
            end
            diff[k] = dro_pkg::DIFF_W'(n_val[k]) - dro_pkg::DIFF_W'(n_off[k]);
        end

        case (i_cfg.first_mode)
            dro_pkg::FIRST_XY: first = dro_pkg::DISP_W'(diff[0]) + dro_pkg::DISP_W'(diff[1]);
            dro_pkg::FIRST_XZ: first = dro_pkg::DISP_W'(diff[0]) + dro_pkg::DISP_W'(diff[2]);
            default:           first = dro_pkg::DISP_W'(diff[0]);
        endcase

        if (i_cfg.second_mode == dro_pkg::SECOND_YZ) begin
            second = dro_pkg::DISP_W'(diff[1]) + dro_pkg::DISP_W'(diff[2]);
        end else begin
            second = dro_pkg::DISP_W'(diff[1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int k = 0; k < dro_pkg::AXES; k++) begin
                r_val[k] <= '0;
                r_off[k] <= '0;
                r_cnt[k] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            for (int k = 0; k < dro_pkg::AXES; k++) begin
                r_val[k] <= n_val[k];
                r_off[k] <= n_off[k];
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame_ok <= i_cmd.ok;
            r_first    <= first;
            r_second   <= second;
            r_third    <= diff[2];
        end
    end

    assign o_valid          = r_valid;
    assign o_frame_ok       = r_frame_ok;
    assign o_first_display  = r_first;
    assign o_second_display = r_second;
    assign o_third_display  = r_third;

endmodule

>>> sv/dro_gauge_frame_axis_readout_core.sv
// An accepted item's result passes through the input register, the queue and the output
// register. Throughput: one item per cycle while the output is not stalled; the output
// register lets input continue while a result waits.
// The queue of QUEUE_DEPTH entries absorbs output stalls before the input stalls.
// Reset (synchronous, active low) clears all axis values, offsets and bad-frame counts,
// empties the pipeline and sets display modes to 0 and the retry limit to 30.
module dro_gauge_frame_axis_readout_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [1:0]                           i_cfg_addr,
    input  logic [dro_pkg::CNT_W-1:0]            i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_action,
    input  logic [dro_pkg::AXIS_W-1:0]           i_axis,
    input  logic [dro_pkg::BYTE_W-1:0]           i_low_byte,
    input  logic [dro_pkg::BYTE_W-1:0]           i_mid_byte,
    input  logic [dro_pkg::BYTE_W-1:0]           i_high_byte,
    input  logic [dro_pkg::BYTE_W-1:0]           i_check_byte,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_frame_ok,
    output logic signed [dro_pkg::DISP_W-1:0]    o_first_display,
    output logic signed [dro_pkg::DISP_W-1:0]    o_second_display,
    output logic signed [dro_pkg::DIFF_W-1:0]    o_third_display
);

    dro_pkg::t_cfg r_cfg;
    dro_pkg::t_cmd push_cmd;
    dro_pkg::t_cmd pop_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_mode  <= dro_pkg::FIRST_X;
            r_cfg.second_mode <= dro_pkg::SECOND_Y;
            r_cfg.retry_limit <= dro_pkg::RETRY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dro_pkg::CFG_FIRST_MODE:  r_cfg.first_mode  <= i_cfg_wdata[1:0];
                dro_pkg::CFG_SECOND_MODE: r_cfg.second_mode <= i_cfg_wdata[0];
                dro_pkg::CFG_RETRY_LIMIT: r_cfg.retry_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    dro_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_axis       (i_axis),
        .i_low_byte   (i_low_byte),
        .i_mid_byte   (i_mid_byte),
        .i_high_byte  (i_high_byte),
        .i_check_byte (i_check_byte),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    dro_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(dro_pkg::t_cmd))
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (empty)
    );

    dro_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (pop_cmd),
        .i_empty          (empty),
        .o_pop            (pop),
        .i_cfg            (r_cfg),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_ok       (o_frame_ok),
        .o_first_display  (o_first_display),
        .o_second_display (o_second_display),
        .o_third_display  (o_third_display)
    );

endmodule

>>> sv/dro_chk.sv
// Port-level checks for the readout core, bound to the top level.
module dro_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic                              o_frame_ok,
    input logic signed [dro_pkg::DISP_W-1:0] o_first_display,
    input logic signed [dro_pkg::DISP_W-1:0] o_second_display,
    input logic signed [dro_pkg::DIFF_W-1:0] o_third_display
);

    // nothing in flight right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_ready)
        else $error("input not ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_ok)
            && $stable(o_first_display) && $stable(o_second_display)
            && $stable(o_third_display))
        else $error("stalled result changed");

    // z difference of two 21-bit values never reaches the 22-bit extremes
    a_third_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_third_display != 22'sh200000) && (o_third_display != 22'sh200001)
            && (o_third_display != 22'sh1fffff))
        else $error("third display out of range");

endmodule

bind dro_gauge_frame_axis_readout_core dro_chk u_chk (.*);

>>> test/dro_gauge_frame_axis_readout_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the three-axis gauge readout core.
module dro_gauge_frame_axis_readout_core_tb;

    localparam int unsigned RUN_LIMIT   = 200000;
    localparam int unsigned HOLD_CYCLES = 50;

    typedef struct {
        logic                       action;
        logic [dro_pkg::AXIS_W-1:0] axis;
        logic [dro_pkg::BYTE_W-1:0] low_byte;
        logic [dro_pkg::BYTE_W-1:0] mid_byte;
        logic [dro_pkg::BYTE_W-1:0] high_byte;
        logic [dro_pkg::BYTE_W-1:0] check_byte;
    } t_gauge_item;

    typedef struct {
        logic                              frame_ok;
        logic signed [dro_pkg::DISP_W-1:0] first_disp;
        logic signed [dro_pkg::DISP_W-1:0] second_disp;
        logic signed [dro_pkg::DIFF_W-1:0] third_disp;
    } t_readout;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [1:0]                        i_cfg_addr;
    logic [dro_pkg::CNT_W-1:0]         i_cfg_wdata;
    logic                              i_valid;
    logic                              o_ready;
    logic                              i_action;
    logic [dro_pkg::AXIS_W-1:0]        i_axis;
    logic [dro_pkg::BYTE_W-1:0]        i_low_byte;
    logic [dro_pkg::BYTE_W-1:0]        i_mid_byte;
    logic [dro_pkg::BYTE_W-1:0]        i_high_byte;
    logic [dro_pkg::BYTE_W-1:0]        i_check_byte;
    logic                              o_valid;
    logic                              i_ready;
    logic                              o_frame_ok;
    logic signed [dro_pkg::DISP_W-1:0] o_first_display;
    logic signed [dro_pkg::DISP_W-1:0] o_second_display;
    logic signed [dro_pkg::DIFF_W-1:0] o_third_display;

    dro_gauge_frame_axis_readout_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_axis           (i_axis),
        .i_low_byte       (i_low_byte),
        .i_mid_byte       (i_mid_byte),
        .i_high_byte      (i_high_byte),
        .i_check_byte     (i_check_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_ok       (o_frame_ok),
        .o_first_display  (o_first_display),
        .o_second_display (o_second_display),
        .o_third_display  (o_third_display)
    );

    // Predicted axis state and register copies
    logic signed [dro_pkg::VAL_W-1:0] pred_value [dro_pkg::AXES];
    logic signed [dro_pkg::VAL_W-1:0] gauge_offset [dro_pkg::AXES];
    logic [dro_pkg::CNT_W-1:0]        miss_count [dro_pkg::AXES];
    logic [1:0]                       disp1_mode = dro_pkg::FIRST_X;
    logic                             disp2_mode = dro_pkg::SECOND_Y;
    logic [dro_pkg::CNT_W-1:0]        retry_limit_cfg = dro_pkg::RETRY_RESET;

    t_gauge_item frames_to_send [$];
    t_readout    expected_readouts [$];
    t_gauge_item cur_item;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    initial begin
        for (int k = 0; k < dro_pkg::AXES; k++) begin
            pred_value[k]   = '0;
            gauge_offset[k] = '0;
            miss_count[k]   = '0;
        end
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_readout readout_after(t_gauge_item it);
        t_readout                   r;
        logic [dro_pkg::BYTE_W-1:0] sum;
        integer                     mag;
        integer                     dx, dy, dz, f, s;
        sum = it.low_byte + it.mid_byte + it.high_byte;
        r.frame_ok = (it.action == dro_pkg::ACT_FRAME) && (sum == it.check_byte);
        if (it.action == dro_pkg::ACT_FRAME) begin
            if (it.axis < dro_pkg::AXES) begin
                if (r.frame_ok) begin
                    mag = 32'({it.high_byte[3:0], it.mid_byte, it.low_byte});
                    pred_value[it.axis] =
                        dro_pkg::VAL_W'(it.high_byte[dro_pkg::SIGN_BIT] ? -mag : mag);
                    miss_count[it.axis] = '0;
                end else begin
                    if (miss_count[it.axis] != dro_pkg::CNT_MAX)
                        miss_count[it.axis] = miss_count[it.axis] + 1'b1;
                    if (miss_count[it.axis] >= retry_limit_cfg)
                        pred_value[it.axis] = '0;
                end
            end
        end else if (it.axis < dro_pkg::AXES) begin
            gauge_offset[it.axis] = pred_value[it.axis];
        end
        dx = 32'(pred_value[0] - gauge_offset[0]);
        dy = 32'(pred_value[1] - gauge_offset[1]);
        dz = 32'(pred_value[2] - gauge_offset[2]);
        case (disp1_mode)
            dro_pkg::FIRST_XY: f = dx + dy;
            dro_pkg::FIRST_XZ: f = dx + dz;
            default:           f = dx;
        endcase
        s = (disp2_mode == dro_pkg::SECOND_YZ) ? dy + dz : dy;
        r.first_disp  = f[dro_pkg::DISP_W-1:0];
        r.second_disp = s[dro_pkg::DISP_W-1:0];
        r.third_disp  = dz[dro_pkg::DIFF_W-1:0];
        return r;
    endfunction

    function automatic t_gauge_item raw_item(logic act, logic [dro_pkg::AXIS_W-1:0] ax,
                                             logic [dro_pkg::BYTE_W-1:0] b0,
                                             logic [dro_pkg::BYTE_W-1:0] b1,
                                             logic [dro_pkg::BYTE_W-1:0] b2,
                                             logic [dro_pkg::BYTE_W-1:0] b3);
        t_gauge_item it;
        it.action     = act;
        it.axis       = ax;
        it.low_byte   = b0;
        it.mid_byte   = b1;
        it.high_byte  = b2;
        it.check_byte = b3;
        return it;
    endfunction

    function automatic t_gauge_item frame_item(logic [dro_pkg::AXIS_W-1:0] ax,
                                               logic [dro_pkg::MAG_W-1:0] mag,
                                               logic neg, logic good);
        t_gauge_item                it;
        logic [dro_pkg::BYTE_W-1:0] sum;
        it.action    = dro_pkg::ACT_FRAME;
        it.axis      = ax;
        it.low_byte  = mag[7:0];
        it.mid_byte  = mag[15:8];
        it.high_byte = {3'($urandom), neg, mag[19:16]};
        sum = it.low_byte + it.mid_byte + it.high_byte;
        it.check_byte = good ? sum : sum + 8'($urandom_range(1, 255));
        return it;
    endfunction

    function automatic t_gauge_item zero_item(logic [dro_pkg::AXIS_W-1:0] ax);
        return raw_item(dro_pkg::ACT_ZERO, ax, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom));
    endfunction

    function automatic logic [dro_pkg::MAG_W-1:0] rand_mag();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        else if (r < 30)
            return '1;
        return dro_pkg::MAG_W'($urandom);
    endfunction

    function automatic t_gauge_item random_item();
        int unsigned                r;
        logic [dro_pkg::AXIS_W-1:0] ax;
        r  = $urandom_range(0, 99);
        ax = dro_pkg::AXIS_W'($urandom_range(0, dro_pkg::AXES - 1));
        if (r < 60)
            return frame_item(ax, rand_mag(), 1'($urandom_range(0, 1)), 1'b1);
        else if (r < 78)
            return frame_item(ax, rand_mag(), 1'($urandom_range(0, 1)), 1'b0);
        else if (r < 90)
            return zero_item(ax);
        else if (r < 95)
            return frame_item(2'd3, rand_mag(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
        return raw_item(1'($urandom_range(0, 1)), dro_pkg::AXIS_W'($urandom_range(0, 3)),
                        8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Mostly single items, with occasional runs of bad frames on one axis
    task automatic queue_random(int unsigned n);
        int unsigned                queued;
        int unsigned                run_len;
        logic [dro_pkg::AXIS_W-1:0] ax;
        queued = 0;
        while (queued < n) begin
            if ($urandom_range(0, 99) < 4) begin
                run_len = $urandom_range(2, 34);
                ax = dro_pkg::AXIS_W'($urandom_range(0, dro_pkg::AXES - 1));
                repeat (run_len)
                    frames_to_send.push_back(frame_item(ax, rand_mag(),
                                                        1'($urandom_range(0, 1)), 1'b0));
                queued += run_len;
            end else begin
                frames_to_send.push_back(random_item());
                queued++;
            end
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [dro_pkg::CNT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            dro_pkg::CFG_FIRST_MODE:  disp1_mode = data[1:0];
            dro_pkg::CFG_SECOND_MODE: disp2_mode = data[0];
            dro_pkg::CFG_RETRY_LIMIT: retry_limit_cfg = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        do
            @(negedge i_clk);
        while (frames_to_send.size() != 0 || i_valid || expected_readouts.size() != 0);
    endtask

    task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n);
        @(negedge i_clk);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        queue_random(n);
        drain();
    endtask

    task automatic check_field(string what, integer want, integer got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : driver
        logic valid_next;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            valid_next = i_valid;
            if (i_valid && o_ready) begin
                expected_readouts.push_back(readout_after(cur_item));
                valid_next = 1'b0;
            end
            if (!valid_next && frames_to_send.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_item = frames_to_send.pop_front();
                i_action     <= cur_item.action;
                i_axis       <= cur_item.axis;
                i_low_byte   <= cur_item.low_byte;
                i_mid_byte   <= cur_item.mid_byte;
                i_high_byte  <= cur_item.high_byte;
                i_check_byte <= cur_item.check_byte;
                valid_next = 1'b1;
            end
            i_valid <= valid_next;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_readout want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_readouts.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, frame_ok %0d first %0d second %0d third %0d",
                             $time, o_frame_ok, o_first_display, o_second_display,
                             o_third_display);
                end else begin
                    want = expected_readouts.pop_front();
                    check_field("frame_ok", 32'(want.frame_ok), 32'(o_frame_ok));
                    check_field("first display", 32'(want.first_disp), 32'(o_first_display));
                    check_field("second display", 32'(want.second_disp),
                                32'(o_second_display));
                    check_field("third display", 32'(want.third_disp), 32'(o_third_display));
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = dro_pkg::CFG_FIRST_MODE;
        i_cfg_wdata  = '0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_action     = dro_pkg::ACT_FRAME;
        i_axis       = '0;
        i_low_byte   = '0;
        i_mid_byte   = '0;
        i_high_byte  = '0;
        i_check_byte = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        frames_to_send.push_back(frame_item(2'd0, 20'hFFFFF, 1'b0, 1'b1));
        frames_to_send.push_back(frame_item(2'd1, 20'hFFFFF, 1'b1, 1'b1));
        frames_to_send.push_back(frame_item(2'd2, 20'h00000, 1'b1, 1'b1));  // minus zero
        frames_to_send.push_back(frame_item(2'd2, 20'hFFFFF, 1'b1, 1'b1));
        frames_to_send.push_back(zero_item(2'd0));
        frames_to_send.push_back(frame_item(2'd0, 20'hFFFFF, 1'b1, 1'b1));
        frames_to_send.push_back(zero_item(2'd2));
        frames_to_send.push_back(frame_item(2'd2, 20'hFFFFF, 1'b0, 1'b1));
        frames_to_send.push_back(frame_item(2'd0, 20'h12345, 1'b0, 1'b0));
        frames_to_send.push_back(frame_item(2'd3, 20'h54321, 1'b0, 1'b1));  // no such axis
        frames_to_send.push_back(frame_item(2'd3, 20'h54321, 1'b1, 1'b0));
        frames_to_send.push_back(zero_item(2'd3));
        frames_to_send.push_back(zero_item(2'd1));
        frames_to_send.push_back(raw_item(dro_pkg::ACT_ZERO, 2'd0, 8'h01, 8'h02, 8'h03, 8'h06));
        frames_to_send.push_back(raw_item(dro_pkg::ACT_FRAME, 2'd0, 8'hFF, 8'hFF, 8'hFF,
                                          8'hFD));
        frames_to_send.push_back(raw_item(dro_pkg::ACT_FRAME, 2'd1, 8'hFF, 8'hFF, 8'hFF,
                                          8'hFF));
        frames_to_send.push_back(raw_item(dro_pkg::ACT_FRAME, 2'd0, 8'h00, 8'h00, 8'h00,
                                          8'h00));
        frames_to_send.push_back(raw_item(dro_pkg::ACT_ZERO, 2'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        drain();

        write_reg(dro_pkg::CFG_FIRST_MODE, dro_pkg::CNT_W'(dro_pkg::FIRST_XY));
        write_reg(dro_pkg::CFG_SECOND_MODE, dro_pkg::CNT_W'(dro_pkg::SECOND_YZ));
        write_reg(dro_pkg::CFG_RETRY_LIMIT, 5'd3);
        run_phase(0, 0, 160);

        write_reg(dro_pkg::CFG_FIRST_MODE, dro_pkg::CNT_W'(dro_pkg::FIRST_XZ));
        write_reg(dro_pkg::CFG_SECOND_MODE, dro_pkg::CNT_W'(dro_pkg::SECOND_Y));
        write_reg(dro_pkg::CFG_RETRY_LIMIT, 5'd1);
        run_phase(76, 0, 160);

        // mode 3 falls back to x only; a zero limit clears on every bad frame
        write_reg(dro_pkg::CFG_FIRST_MODE, 5'd3);
        write_reg(dro_pkg::CFG_RETRY_LIMIT, 5'd0);
        run_phase(0, 76, 160);

        write_reg(dro_pkg::CFG_FIRST_MODE, 5'b11100);
        write_reg(dro_pkg::CFG_SECOND_MODE, 5'b11111);
        write_reg(dro_pkg::CFG_RETRY_LIMIT, 5'd31);
        write_reg(2'd3, 5'b10101);
        run_phase(7, 7, 160);

        // receiver holds off while the sender keeps offering
        write_reg(dro_pkg::CFG_FIRST_MODE, dro_pkg::CNT_W'(dro_pkg::FIRST_XY));
        @(negedge i_clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(60);
        hold_req = 1'b1;
        drain();

        write_reg(dro_pkg::CFG_FIRST_MODE, dro_pkg::CNT_W'(dro_pkg::FIRST_XZ));
        write_reg(dro_pkg::CFG_SECOND_MODE, dro_pkg::CNT_W'(dro_pkg::SECOND_YZ));
        write_reg(dro_pkg::CFG_RETRY_LIMIT, dro_pkg::RETRY_RESET);
        run_phase(7, 76, 140);

        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> filelist.f
sv/dro_pkg.sv
sv/dro_front.sv
sv/dro_fifo.sv
sv/dro_back.sv
sv/dro_gauge_frame_axis_readout_core.sv
sv/dro_chk.sv
test/dro_gauge_frame_axis_readout_core_tb.sv
